// ===== sv/bsd_pkg.sv =====
package bsd_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 7;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        KIND_PUSH    = 2'd0,
        KIND_POP     = 2'd1,
        KIND_DUMP_TB = 2'd2,
        KIND_DUMP_BT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_ENTRY = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } state_t;

endpackage

// ===== sv/bounded_stack_with_dump.sv =====
// push and pop complete in the single cycle they are accepted, with no result on success
// an error gives one result, presented the cycle after the input transfer
// a dump streams each entry by a memory read, then the output register, while input stalls
// a dump of n entries holds the input off until the output has taken all n entries
// asynchronous active-low reset empties the stack and sets capacity to 64; entries are not cleared
module bounded_stack_with_dump
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       kind,
    input  logic signed [bsd_pkg::DATA_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic signed [bsd_pkg::DATA_W-1:0] data,
    output logic                             last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bsd_pkg::CAP_W-1:0]        cfg_data
);

    bsd_pkg::state_t                 state_reg, state_next;
    logic [bsd_pkg::CNT_W-1:0]       fill_reg, fill_next;
    logic [bsd_pkg::CAP_W-1:0]       cap_reg;
    logic [bsd_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic                            dir_reg, dir_next;
    bsd_pkg::status_t                status_reg, status_next;
    logic                            last_reg, last_next;
    logic [bsd_pkg::DATA_W-1:0]      rd_data_reg;
    logic [bsd_pkg::DATA_W-1:0]      entry_mem [bsd_pkg::DEPTH];

    logic [bsd_pkg::CNT_W-1:0]       limit;
    logic [bsd_pkg::CNT_W-1:0]       fill_dec;
    logic                            wr_en;
    logic                            rd_en;
    logic                            in_xfer;

    assign in_xfer   = in_valid && in_ready;
    assign in_ready  = (state_reg == bsd_pkg::S_IDLE);
    assign out_valid = (state_reg == bsd_pkg::S_OUT);
    assign cfg_ready = 1'b1;
    assign status    = status_reg;
    assign last      = last_reg;
    assign data      = (status_reg == bsd_pkg::ST_ENTRY) ? rd_data_reg : '0;
    assign fill_dec  = fill_reg - bsd_pkg::CNT_W'(1);

    always_comb
    begin
        if ({1'b0, cap_reg} < {{(bsd_pkg::CAP_W + 1 - bsd_pkg::CNT_W){1'b0}}, bsd_pkg::DEPTH_CNT})
        begin
            limit = bsd_pkg::CNT_W'(cap_reg);
        end
        else
        begin
            limit = bsd_pkg::DEPTH_CNT;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        addr_next   = addr_reg;
        dir_next    = dir_reg;
        status_next = status_reg;
        last_next   = last_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        case (state_reg)
            bsd_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (kind == bsd_pkg::KIND_PUSH)
                    begin
                        if (fill_reg < limit)
                        begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + bsd_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            status_next = bsd_pkg::ST_FULL;
                            last_next   = 1'b1;
                            state_next  = bsd_pkg::S_OUT;
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        status_next = bsd_pkg::ST_EMPTY;
                        last_next   = 1'b1;
                        state_next  = bsd_pkg::S_OUT;
                    end
                    else if (kind == bsd_pkg::KIND_POP)
                    begin
                        fill_next = fill_dec;
                    end
                    else
                    begin
                        // top to bottom walks down from the newest entry
                        dir_next   = (kind == bsd_pkg::KIND_DUMP_TB);
                        addr_next  = (kind == bsd_pkg::KIND_DUMP_TB) ?
                                     fill_dec[bsd_pkg::ADDR_W-1:0] : '0;
                        state_next = bsd_pkg::S_READ;
                    end
                end
            end
            bsd_pkg::S_READ:
            begin
                rd_en       = 1'b1;
                status_next = bsd_pkg::ST_ENTRY;
                last_next   = dir_reg ? (addr_reg == '0) :
                              (addr_reg == fill_dec[bsd_pkg::ADDR_W-1:0]);
                state_next  = bsd_pkg::S_OUT;
            end
            bsd_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = bsd_pkg::S_IDLE;
                    end
                    else
                    begin
                        addr_next  = dir_reg ? (addr_reg - bsd_pkg::ADDR_W'(1)) :
                                     (addr_reg + bsd_pkg::ADDR_W'(1));
                        state_next = bsd_pkg::S_READ;
                    end
                end
            end
            default:
            begin
                state_next = bsd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bsd_pkg::S_IDLE;
            fill_reg   <= '0;
            cap_reg    <= bsd_pkg::CAP_W'(64);
            last_reg   <= 1'b0;
            status_reg <= bsd_pkg::ST_ENTRY;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            last_reg   <= last_next;
            status_reg <= status_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        dir_reg  <= dir_next;
    end

    // stack memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[fill_reg[bsd_pkg::ADDR_W-1:0]] <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[addr_reg];
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= bsd_pkg::DEPTH_CNT)
        else $error("fill count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (kind == bsd_pkg::KIND_PUSH) && (fill_reg < limit)
        |=> fill_reg == $past(fill_reg) + bsd_pkg::CNT_W'(1))
        else $error("accepted push did not grow the stack");

    a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_reg |=> !in_ready && !out_valid)
        else $error("dump ended before last entry");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status_reg != bsd_pkg::ST_ENTRY) |-> last_reg && (data == '0))
        else $error("error result not final or data nonzero");

    a_dump_holds_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(fill_reg))
        else $error("fill count changed during output");
`endif

endmodule
